/* hdl/bra_pkg.sv */
// Package for the bitmap run allocator.
// Holds the map sizes, the action codes, the controller states and the
// command and status words between the controller and the datapath.
`default_nettype none

package bra_pkg;

    localparam int MAP_BITS    = 1024;
    localparam int STORE_BYTES = (MAP_BITS + 7) / 8;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int NBITS_W     = 11;
    localparam int IDX_W       = 10;
    localparam int LEN_W       = 11;
    localparam int CFG_W       = 8;

    localparam logic [CFG_W-1:0] MAP_BYTES_RST = 8'd128;

    typedef enum logic [1:0] {
        ACT_FIND  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TEST  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_READ,
        ST_MODIFY,
        ST_CLEAR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic rd_idx;
        logic modify;
        logic clear_map;
        logic scan_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
        logic res_free;
    } status_t;

endpackage

`default_nettype wire

/* hdl/bra_ctrl.sv */
// Controller state machine of the bitmap run allocator.
// Depends on bra_pkg for the action codes, states, command and status words.
`default_nettype none

module bra_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       in_action,
    input  wire bra_pkg::status_t status,
    output logic                  in_ready,
    output bra_pkg::cmd_t         cmd
);
    import bra_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action_t'(in_action))
                        ACT_FIND:  state_next = ST_SCAN;
                        ACT_WRITE: state_next = ST_READ;
                        ACT_TEST:  state_next = ST_READ;
                        ACT_CLEAR: state_next = ST_CLEAR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_READ:   state_next = ST_MODIFY;
            ST_MODIFY: state_next = ST_FIN;
            ST_CLEAR:  state_next = ST_FIN;
            ST_FIN:
            begin
                if (status.res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.latch_in = in_valid;
            end
            ST_SCAN:   cmd.scan_step = 1'b1;
            ST_READ:   cmd.rd_idx    = 1'b1;
            ST_MODIFY: cmd.modify    = 1'b1;
            ST_CLEAR:  cmd.clear_map = 1'b1;
            ST_FIN:    cmd.load_out  = status.res_free;
            default:   cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/bra_dp.sv */
// Datapath of the bitmap run allocator: map memory with valid bits, the
// byte-wide run scanner, the map size register and the result register.
// Depends on bra_pkg; driven by commands from bra_ctrl.
`default_nettype none

module bra_dp (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bra_pkg::cmd_t             cmd,
    output bra_pkg::status_t               status,
    input  wire logic [1:0]                in_action,
    input  wire logic [bra_pkg::IDX_W-1:0] in_bit_index,
    input  wire logic [bra_pkg::LEN_W-1:0] in_run_length,
    input  wire logic                      in_bit_value,
    input  wire logic                      cfg_valid,
    input  wire logic [bra_pkg::CFG_W-1:0] cfg_data,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           found,
    output logic [bra_pkg::IDX_W-1:0]      start_index,
    output logic                           bit_read
);
    import bra_pkg::*;

    logic [7:0]         mem [0:STORE_BYTES-1];
    logic [STORE_BYTES-1:0] vld_reg;
    logic [7:0]         rdata_reg;
    logic               rvld_reg;
    logic [7:0]         rbyte;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [7:0]         wbyte;
    logic [7:0]         wmask;

    logic [CFG_W-1:0]   map_bytes_reg;
    logic [1:0]         action_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               val_reg;

    logic [NBITS_W-1:0] raw_bits;
    logic [NBITS_W-1:0] nbits;
    logic [CFG_W-1:0]   nbytes;
    logic               idx_ok;
    logic               len_ok;

    logic [CFG_W-1:0]   scan_addr_reg;
    logic [ADDR_W-1:0]  proc_addr_reg;
    logic               proc_vld_reg;
    logic [LEN_W-1:0]   run_reg;
    logic [LEN_W-1:0]   run_v;
    logic               hit_v;
    logic [2:0]         hit_pos;
    logic               hit_now;
    logic               more_bytes;
    logic [LEN_W-1:0]   start_calc;

    logic               pend_found_reg;
    logic [IDX_W-1:0]   pend_start_reg;
    logic               pend_bit_reg;
    logic               out_valid_reg;

    assign raw_bits = {map_bytes_reg, 3'b000};
    assign nbits    = (raw_bits > NBITS_W'(MAP_BITS)) ? NBITS_W'(MAP_BITS) : raw_bits;
    assign nbytes   = (map_bytes_reg > CFG_W'(STORE_BYTES)) ? CFG_W'(STORE_BYTES)
                                                            : map_bytes_reg;
    assign idx_ok   = {1'b0, idx_reg} < nbits;
    assign len_ok   = (len_reg != '0) && (len_reg <= nbits);

    assign more_bytes = scan_addr_reg < nbytes;
    assign rd_en   = cmd.rd_idx || (cmd.scan_step && more_bytes);
    assign rd_addr = cmd.scan_step ? scan_addr_reg[ADDR_W-1:0] : idx_reg[IDX_W-1:3];
    assign rbyte   = rvld_reg ? rdata_reg : 8'h00;

    assign wmask = 8'h01 << idx_reg[2:0];
    assign wbyte = val_reg ? (rbyte | wmask) : (rbyte & ~wmask);
    assign wr_en = cmd.modify && (action_t'(action_reg) == ACT_WRITE) && idx_ok;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[idx_reg[IDX_W-1:3]] <= wbyte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                rvld_reg <= vld_reg[rd_addr];
            end
            if (cmd.clear_map)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[idx_reg[IDX_W-1:3]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_bytes_reg <= MAP_BYTES_RST;
        end
        else if (cfg_valid)
        begin
            map_bytes_reg <= cfg_data;
        end
    end

    always_comb
    begin
        run_v   = run_reg;
        hit_v   = 1'b0;
        hit_pos = 3'd0;
        for (int j = 0; j < 8; j++)
        begin
            if (rbyte[j])
            begin
                run_v = '0;
            end
            else
            begin
                run_v = run_v + LEN_W'(1);
            end
            if (!hit_v && (run_v == len_reg))
            begin
                hit_v   = 1'b1;
                hit_pos = 3'(j);
            end
        end
    end

    assign hit_now    = proc_vld_reg && hit_v && len_ok;
    assign start_calc = LEN_W'({1'b0, proc_addr_reg, hit_pos}) + LEN_W'(1) - len_reg;

    assign status.scan_done = !len_ok || hit_now || (!proc_vld_reg && !more_bytes);
    assign status.res_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            action_reg     <= in_action;
            idx_reg        <= in_bit_index;
            len_reg        <= in_run_length;
            val_reg        <= in_bit_value;
            run_reg        <= '0;
            pend_found_reg <= 1'b0;
            pend_start_reg <= '0;
            pend_bit_reg   <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (proc_vld_reg)
            begin
                run_reg <= run_v;
            end
            if (hit_now)
            begin
                pend_found_reg <= 1'b1;
                pend_start_reg <= start_calc[IDX_W-1:0];
            end
        end
        else if (cmd.modify)
        begin
            pend_found_reg <= idx_ok;
            pend_bit_reg   <= (action_t'(action_reg) == ACT_TEST) && idx_ok
                              && rbyte[idx_reg[2:0]];
        end
        else if (cmd.clear_map)
        begin
            pend_found_reg <= 1'b1;
        end
        if (cmd.load_out)
        begin
            found       <= pend_found_reg;
            start_index <= pend_start_reg;
            bit_read    <= pend_bit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
            proc_addr_reg <= '0;
            proc_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.latch_in)
            begin
                scan_addr_reg <= '0;
                proc_vld_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                proc_vld_reg <= more_bytes;
                if (more_bytes)
                begin
                    proc_addr_reg <= scan_addr_reg[ADDR_W-1:0];
                    scan_addr_reg <= scan_addr_reg + CFG_W'(1);
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/bitmap_run_allocator.sv */
// Top level of the bitmap run allocator: joins the controller and datapath.
// Depends on bra_pkg, bra_ctrl and bra_dp.
//
// The block keeps a 1024-bit allocation map in a 128-byte memory and takes one
// request word at a time. A find reads up to min(map_bytes, 128) map bytes,
// one byte per cycle through the memory's single read port, and stops early
// when a run is found. A write does a read-modify-write on the same port, a
// test reads the indexed byte and a clear empties the valid bits. A finished
// result waits in the output register while the block takes the next request,
// and the configuration port is always ready.
`default_nettype none

module bitmap_run_allocator (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [1:0]                action,
    input  wire logic [bra_pkg::IDX_W-1:0] bit_index,
    input  wire logic [bra_pkg::LEN_W-1:0] run_length,
    input  wire logic                      bit_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           found,
    output logic [bra_pkg::IDX_W-1:0]      start_index,
    output logic                           bit_read,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [bra_pkg::CFG_W-1:0] map_bytes
);
    import bra_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    bra_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_action (action),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    bra_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_action     (action),
        .in_bit_index  (bit_index),
        .in_run_length (run_length),
        .in_bit_value  (bit_value),
        .cfg_valid     (cfg_valid),
        .cfg_data      (map_bytes),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .start_index   (start_index),
        .bit_read      (bit_read)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while a previous one is in progress");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid || out_ready))
        else $error("result register overwritten before it was taken");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.latch_in, cmd.rd_idx, cmd.modify, cmd.clear_map,
                  cmd.scan_step, cmd.load_out}))
        else $error("controller issued more than one command");

    a_read_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bit_read) |-> found)
        else $error("bit read reported for an index outside the map");

endmodule

`default_nettype wire

/* tb/sv/tb_bitmap_run_allocator.sv */
// Self-checking testbench for the bitmap run allocator: a request driver and a
// result monitor check every result word against a predictor of the allocation map.
// Depends on bra_pkg and the bitmap_run_allocator top level.

module tb_bitmap_run_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import bra_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 12;

    typedef struct packed {
        action_t          act;
        logic [IDX_W-1:0] idx;
        logic [LEN_W-1:0] len;
        logic             val;
        logic             drain_first;
    } alloc_request_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] start;
        logic             rd;
    } alloc_result_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [1:0]       action      = 2'd0;
    logic [IDX_W-1:0] bit_index   = '0;
    logic [LEN_W-1:0] run_length  = '0;
    logic             bit_value   = 1'b0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic             found;
    logic [IDX_W-1:0] start_index;
    logic             bit_read;
    logic             cfg_valid   = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] map_bytes   = '0;

    bitmap_run_allocator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .bit_index   (bit_index),
        .run_length  (run_length),
        .bit_value   (bit_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .start_index (start_index),
        .bit_read    (bit_read),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .map_bytes   (map_bytes)
    );

    always #2 clk = ~clk;

    alloc_request_t    pending_requests[$];
    alloc_result_t     expected_results[$];
    bit [MAP_BITS-1:0] alloc_map      = '0;
    logic [CFG_W-1:0]  map_size_model = MAP_BYTES_RST;

    bit req_taken   = 1'b0;
    bit idle_on     = 1'b1;
    int send_gap    = 0;
    int recv_stall  = 0;
    int quiet_cycles = 0;

    int requests_queued   = 0;
    int requests_accepted = 0;
    int results_seen      = 0;
    int errors            = 0;
    int finds_hit         = 0;
    int finds_miss        = 0;
    int writes_done       = 0;
    int tests_done        = 0;
    int clears_done       = 0;
    int cfg_writes        = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("mismatch %0d at %0t: %0s got %0d expected %0d", errors, $realtime, what,
                     got, want);
    endtask

    function automatic alloc_result_t predict_request(action_t act, logic [IDX_W-1:0] idx,
                                                      logic [LEN_W-1:0] len, logic val);
        alloc_result_t r;
        int nbits;
        int run;
        r = '0;
        nbits = int'(map_size_model) * 8;
        if (nbits > MAP_BITS)
            nbits = MAP_BITS;
        case (act)
            ACT_FIND:
            begin
                if (len != 0 && int'(len) <= nbits)
                begin
                    run = 0;
                    for (int i = 0; i < nbits; i++)
                    begin
                        if (alloc_map[i])
                            run = 0;
                        else
                            run++;
                        if (run == int'(len))
                        begin
                            r.found = 1'b1;
                            r.start = IDX_W'(i + 1 - int'(len));
                            break;
                        end
                    end
                end
                if (r.found)
                    finds_hit++;
                else
                    finds_miss++;
            end
            ACT_WRITE:
            begin
                writes_done++;
                if (int'(idx) < nbits)
                begin
                    alloc_map[idx] = val;
                    r.found = 1'b1;
                end
            end
            ACT_TEST:
            begin
                tests_done++;
                if (int'(idx) < nbits)
                begin
                    r.rd = alloc_map[idx];
                    r.found = 1'b1;
                end
            end
            default:
            begin
                clears_done++;
                alloc_map = '0;
                r.found = 1'b1;
            end
        endcase
        return r;
    endfunction

    task automatic queue_request(input action_t act, input int idx, input int len,
                                 input bit val, input bit drain);
        alloc_request_t r;
        r.act = act;
        r.idx = IDX_W'(idx);
        r.len = LEN_W'(len);
        r.val = val;
        r.drain_first = drain;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    function automatic alloc_request_t random_request(int nbits, int fill_pct);
        alloc_request_t r;
        int pick;
        int short_max;
        r.idx = IDX_W'($urandom);
        r.len = LEN_W'($urandom);
        r.val = 1'($urandom);
        r.drain_first = ($urandom_range(0, 49) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            r.act = ACT_FIND;
        else if (pick < 75)
            r.act = ACT_WRITE;
        else if (pick < 98)
            r.act = ACT_TEST;
        else
            r.act = ACT_CLEAR;
        if (nbits > 0 && $urandom_range(0, 9) != 0)
        begin
            short_max = (nbits < 12) ? nbits : 12;
            r.idx = IDX_W'($urandom_range(0, nbits - 1));
            if ($urandom_range(0, 3) == 0)
                r.len = LEN_W'($urandom_range(1, nbits + 2));
            else
                r.len = LEN_W'($urandom_range(1, short_max));
        end
        if (r.act == ACT_WRITE)
            r.val = ($urandom_range(0, 99) < fill_pct);
        return r;
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (requests_accepted != requests_queued || expected_results.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_map_size(input logic [CFG_W-1:0] value);
        @(negedge clk);
        map_bytes <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        map_size_model = value;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : accept_requests
        alloc_result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r = predict_request(action_t'(action), bit_index, run_length, bit_value);
            expected_results.push_back(r);
            requests_accepted++;
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin : drive_requests
        alloc_request_t req;
        logic next_valid;
        if (rst_n && !(in_valid && !req_taken))
        begin
            req_taken = 1'b0;
            next_valid = 1'b0;
            if (send_gap > 0)
                send_gap--;
            else if (pending_requests.size() > 0 &&
                     !(pending_requests[0].drain_first && expected_results.size() > 0))
            begin
                req = pending_requests.pop_front();
                action     <= req.act;
                bit_index  <= req.idx;
                run_length <= req.len;
                bit_value  <= req.val;
                next_valid = 1'b1;
                send_gap = idle_on ? $urandom_range(0, 12) : 0;
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result word with nothing pending, found", found, 0);
            else
            begin
                want = expected_results.pop_front();
                if (found !== want.found)
                    report_mismatch("found", found, want.found);
                if (start_index !== want.start)
                    report_mismatch("start_index", start_index, want.start);
                if (bit_read !== want.rd)
                    report_mismatch("bit_read", bit_read, want.rd);
            end
            recv_stall = idle_on ? $urandom_range(0, 12) : 0;
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                    $display("bitmap_run_allocator regression: fail");
                    $finish;
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] sizes[PHASES];
        int nbits;
        int fill_pct;
        alloc_request_t r;

        sizes = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd16, 8'd0, 8'd128, 8'd255, 8'd64,
                  8'd5, 8'd0};
        sizes[6]  = CFG_W'($urandom_range(1, 32));
        sizes[11] = CFG_W'($urandom_range(0, 255));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_request(ACT_TEST,  0,    0,    1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    1,    1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    1024, 1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    1025, 1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    0,    1'b0, 1'b0);
        queue_request(ACT_FIND,  1023, 2047, 1'b1, 1'b0);
        queue_request(ACT_WRITE, 0,    0,    1'b1, 1'b0);
        queue_request(ACT_WRITE, 1023, 0,    1'b1, 1'b0);
        queue_request(ACT_TEST,  1023, 0,    1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    1022, 1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    1023, 1'b0, 1'b0);
        queue_request(ACT_WRITE, 1023, 0,    1'b0, 1'b0);
        queue_request(ACT_CLEAR, 0,    0,    1'b0, 1'b0);
        queue_request(ACT_TEST,  0,    0,    1'b0, 1'b1);
        wait_idle();

        write_map_size(8'd0);
        queue_request(ACT_FIND,  0,    1,    1'b0, 1'b0);
        queue_request(ACT_WRITE, 5,    0,    1'b1, 1'b0);
        queue_request(ACT_TEST,  5,    0,    1'b0, 1'b0);
        wait_idle();

        write_map_size(8'd255);
        queue_request(ACT_WRITE, 1023, 0,    1'b1, 1'b0);
        queue_request(ACT_TEST,  1023, 0,    1'b0, 1'b0);
        wait_idle();

        write_map_size(8'd1);
        queue_request(ACT_WRITE, 8,    0,    1'b1, 1'b0);
        queue_request(ACT_WRITE, 7,    0,    1'b1, 1'b0);
        queue_request(ACT_FIND,  0,    7,    1'b0, 1'b0);
        queue_request(ACT_FIND,  0,    8,    1'b0, 1'b0);
        queue_request(ACT_TEST,  1023, 0,    1'b0, 1'b0);
        queue_request(ACT_CLEAR, 0,    0,    1'b0, 1'b0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            write_map_size(sizes[p]);
            idle_on = !(p == 2 || p == 8);
            nbits = int'(sizes[p]) * 8;
            if (nbits > MAP_BITS)
                nbits = MAP_BITS;
            fill_pct = $urandom_range(20, 90);
            for (int k = 0; k < 82; k++)
            begin
                r = random_request(nbits, fill_pct);
                pending_requests.push_back(r);
                requests_queued++;
            end
            wait_idle();
        end

        repeat (200) @(posedge clk);

        $display("ran %0d requests under %0d map sizes: %0d finds hit, %0d missed, ",
                 requests_accepted, cfg_writes, finds_hit, finds_miss);
        $display("%0d writes, %0d tests, %0d clears; %0d result words checked, %0d mismatches",
                 writes_done, tests_done, clears_done, results_seen, errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("bitmap_run_allocator regression: pass");
        else
            $display("bitmap_run_allocator regression: fail");
        $finish;
    end

endmodule

/* files.f */
hdl/bra_pkg.sv
hdl/bra_ctrl.sv
hdl/bra_dp.sv
hdl/bitmap_run_allocator.sv
tb/sv/tb_bitmap_run_allocator.sv
